/* hdl/cl4_pkg.sv */
// Package with the shared types and constants of the 4-bit character LCD controller.
package cl4_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_PWR_PRE  = 4'd1,
        PH_HI_EN    = 4'd2,
        PH_HI_GAP   = 4'd3,
        PH_LO_EN    = 4'd4,
        PH_LO_GAP   = 4'd5,
        PH_POLL     = 4'd6,
        PH_POST     = 4'd7,
        PH_PWR_POST = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_INIT  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_ENABLE_PULSE = 2'd0,
        REG_POST_WRITE   = 2'd1,
        REG_POWER_WAIT   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    localparam int TICK_W    = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [TICK_W-1:0] tick_t;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h2C;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;

    function automatic logic [7:0] init_cmd(input logic [1:0] step);
        logic [7:0] cmd;
        case (step)
            2'd0:    cmd = CMD_FUNCTION_SET;
            2'd1:    cmd = CMD_DISPLAY_ON;
            2'd2:    cmd = CMD_ENTRY_MODE;
            default: cmd = CMD_CLEAR;
        endcase
        return cmd;
    endfunction

endpackage

/* hdl/cl4_in_if.sv */
// Request channel interface of the 4-bit character LCD controller.
interface cl4_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       reg_select;
    logic [7:0] byte_value;
    logic       busy_pin;

    modport source (output valid, action, reg_select, byte_value, busy_pin, input ready);
    modport sink (input valid, action, reg_select, byte_value, busy_pin, output ready);
endinterface

/* hdl/cl4_out_if.sv */
// Result channel interface of the 4-bit character LCD controller.
interface cl4_out_if;
    logic       valid;
    logic       ready;
    logic       pin_rs;
    logic       pin_rw;
    logic       pin_en;
    logic [3:0] pin_data;
    logic       d7_drive;
    logic       ready_res;
    logic       rejected;

    modport source (output valid, pin_rs, pin_rw, pin_en, pin_data, d7_drive, ready_res,
                    rejected, input ready);
    modport sink (input valid, pin_rs, pin_rw, pin_en, pin_data, d7_drive, ready_res,
                  rejected, output ready);
endinterface

/* hdl/char_lcd_4bit_interface.sv */
// Top level of the 4-bit character LCD controller with its APB register port.
//
//   Channel | Dir | Handshake          | Contents
//   req     | in  | valid/ready        | action, reg_select, byte_value, busy_pin
//   rsp     | out | valid/ready        | pin levels, ready_res, rejected
//   apb     | in  | psel/penable/pready| enable_pulse, post_write, power_wait ticks
//
// Each request is handled in the cycle it is accepted and its result is
// registered, so one request per cycle is sustained while the result channel is ready.
// The result register frees up in the same cycle it is taken, so a request is
// accepted whenever the result register is empty or is being read.
// Reset puts the controller idle with all pins low and D7 driven.
module char_lcd_4bit_interface (
    input  logic                           clk,
    input  logic                           rst_n,
    cl4_in_if.sink                         req,
    cl4_out_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cl4_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cl4_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cl4_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cl4_pkg::*;

    tick_t      enable_pulse_reg;
    tick_t      post_write_reg;
    tick_t      power_wait_reg;
    reg_index_t reg_index;

    phase_t     phase_reg, phase_next;
    tick_t      wait_reg, wait_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_sel_reg, held_sel_next;
    logic [2:0] init_step_reg, init_step_next;
    logic       init_active_reg, init_active_next;
    logic       rs_reg, rs_next;
    logic       rw_reg, rw_next;
    logic       en_reg, en_next;
    logic       drv_reg, drv_next;
    logic [3:0] data_reg, data_next;

    logic       out_valid_reg;
    logic       rejected_next;
    logic       accept;
    logic       wait_done;
    tick_t      pulse_len;
    logic       start_req;
    logic       start_sel;
    logic [7:0] start_byte;
    logic       finish_req;
    logic [2:0] step_inc;

    // The pin levels are the state itself; only the status bits need a result register.
    logic       ready_res_reg;
    logic       rejected_reg;

    assign reg_index = reg_index_t'(paddr[3:2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_pulse_reg <= 16'd1;
            post_write_reg   <= 16'd3;
            power_wait_reg   <= 16'd200;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_ENABLE_PULSE: enable_pulse_reg <= pwdata[TICK_W-1:0];
                REG_POST_WRITE:   post_write_reg   <= pwdata[TICK_W-1:0];
                REG_POWER_WAIT:   power_wait_reg   <= pwdata[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ENABLE_PULSE: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, enable_pulse_reg};
            REG_POST_WRITE:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, post_write_reg};
            REG_POWER_WAIT:   prdata = {{(APB_DATA_W-TICK_W){1'b0}}, power_wait_reg};
            default:          prdata = '0;
        endcase
    end

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign pulse_len = (enable_pulse_reg == '0) ? 16'd1 : enable_pulse_reg;
    assign wait_done = (wait_reg <= 16'd1);
    assign step_inc  = init_step_reg + 3'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        wait_next        = wait_reg;
        held_byte_next   = held_byte_reg;
        held_sel_next    = held_sel_reg;
        init_step_next   = init_step_reg;
        init_active_next = init_active_reg;
        rs_next          = rs_reg;
        rw_next          = rw_reg;
        en_next          = en_reg;
        drv_next         = drv_reg;
        data_next        = data_reg;
        rejected_next    = 1'b0;
        start_req        = 1'b0;
        start_sel        = 1'b0;
        start_byte       = '0;
        finish_req       = 1'b0;

        case (action_t'(req.action))
            ACT_TICK:
            begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_PWR_PRE:
                    begin
                        wait_next = wait_done ? '0 : wait_reg - 16'd1;
                        if (wait_done)
                        begin
                            start_req  = 1'b1;
                            start_byte = init_cmd(2'd0);
                        end
                    end
                    PH_HI_EN:
                    begin
                        wait_next = wait_done ? '0 : wait_reg - 16'd1;
                        if (wait_done)
                        begin
                            en_next    = 1'b0;
                            phase_next = PH_HI_GAP;
                        end
                    end
                    PH_HI_GAP:
                    begin
                        rs_next    = held_sel_reg;
                        rw_next    = 1'b0;
                        en_next    = 1'b1;
                        drv_next   = 1'b1;
                        data_next  = held_byte_reg[3:0];
                        wait_next  = pulse_len;
                        phase_next = PH_LO_EN;
                    end
                    PH_LO_EN:
                    begin
                        wait_next = wait_done ? '0 : wait_reg - 16'd1;
                        if (wait_done)
                        begin
                            en_next    = 1'b0;
                            phase_next = PH_LO_GAP;
                        end
                    end
                    PH_LO_GAP:
                    begin
                        rs_next    = 1'b0;
                        rw_next    = 1'b1;
                        en_next    = 1'b1;
                        drv_next   = 1'b0;
                        data_next  = {1'b0, data_reg[2:0]};
                        phase_next = PH_POLL;
                    end
                    PH_POLL:
                    begin
                        if (!req.busy_pin)
                        begin
                            rs_next   = 1'b0;
                            rw_next   = 1'b0;
                            en_next   = 1'b0;
                            drv_next  = 1'b1;
                            data_next = held_byte_reg[3:0];
                            if (post_write_reg == '0)
                            begin
                                finish_req = 1'b1;
                            end
                            else
                            begin
                                wait_next  = post_write_reg;
                                phase_next = PH_POST;
                            end
                        end
                    end
                    PH_POST:
                    begin
                        wait_next = wait_done ? '0 : wait_reg - 16'd1;
                        finish_req = wait_done;
                    end
                    PH_PWR_POST:
                    begin
                        wait_next = wait_done ? '0 : wait_reg - 16'd1;
                        if (wait_done)
                        begin
                            init_active_next = 1'b0;
                            phase_next       = PH_IDLE;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
            ACT_WRITE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    init_active_next = 1'b0;
                    start_req        = 1'b1;
                    start_sel        = req.reg_select;
                    start_byte       = req.byte_value;
                end
            end
            ACT_INIT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rejected_next = 1'b1;
                end
                else
                begin
                    rs_next          = 1'b0;
                    rw_next          = 1'b0;
                    en_next          = 1'b0;
                    drv_next         = 1'b1;
                    data_next        = '0;
                    init_active_next = 1'b1;
                    init_step_next   = '0;
                    if (power_wait_reg == '0)
                    begin
                        start_req  = 1'b1;
                        start_byte = init_cmd(2'd0);
                    end
                    else
                    begin
                        wait_next  = power_wait_reg;
                        phase_next = PH_PWR_PRE;
                    end
                end
            end
            default: ;
        endcase

        // End of a byte: go idle, move on through the init commands, or start the final power wait.
        if (finish_req)
        begin
            if (!init_active_reg)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                init_step_next = step_inc;
                if (step_inc < 3'd4)
                begin
                    start_req  = 1'b1;
                    start_byte = init_cmd(step_inc[1:0]);
                end
                else if (power_wait_reg == '0)
                begin
                    init_active_next = 1'b0;
                    phase_next       = PH_IDLE;
                end
                else
                begin
                    wait_next  = power_wait_reg;
                    phase_next = PH_PWR_POST;
                end
            end
        end

        if (start_req)
        begin
            held_sel_next  = start_sel;
            held_byte_next = start_byte;
            rs_next        = start_sel;
            rw_next        = 1'b0;
            en_next        = 1'b1;
            drv_next       = 1'b1;
            data_next      = start_byte[7:4];
            wait_next      = pulse_len;
            phase_next     = PH_HI_EN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            wait_reg        <= '0;
            held_byte_reg   <= '0;
            held_sel_reg    <= 1'b0;
            init_step_reg   <= '0;
            init_active_reg <= 1'b0;
            rs_reg          <= 1'b0;
            rw_reg          <= 1'b0;
            en_reg          <= 1'b0;
            drv_reg         <= 1'b1;
            data_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                wait_reg        <= wait_next;
                held_byte_reg   <= held_byte_next;
                held_sel_reg    <= held_sel_next;
                init_step_reg   <= init_step_next;
                init_active_reg <= init_active_next;
                rs_reg          <= rs_next;
                rw_reg          <= rw_next;
                en_reg          <= en_next;
                drv_reg         <= drv_next;
                data_reg        <= data_next;
                out_valid_reg   <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_res_reg <= 1'b1;
            rejected_reg  <= 1'b0;
        end
        else if (accept)
        begin
            ready_res_reg <= (phase_next == PH_IDLE);
            rejected_reg  <= rejected_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pin_rs    = rs_reg;
    assign rsp.pin_rw    = rw_reg;
    assign rsp.pin_en    = en_reg;
    assign rsp.pin_data  = data_reg;
    assign rsp.d7_drive  = drv_reg;
    assign rsp.ready_res = ready_res_reg;
    assign rsp.rejected  = rejected_reg;

endmodule

/* test/testbench.sv */
// Self-checking testbench for the 4-bit character LCD controller: directed table, random requests.
module testbench;
    import cl4_pkg::*;

    typedef struct packed {
        action_t    action;
        logic       sel;
        logic [7:0] data_byte;
        logic       busy;
    } lcd_req_t;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       en;
        logic [3:0] data;
        logic       drv;
        logic       idle;
        logic       rej;
    } pin_result_t;

    typedef struct packed {
        lcd_req_t    req;
        logic        typed;
        pin_result_t want;
    } directed_row_t;

    localparam int DIRECTED_ROWS   = 25;
    localparam int RANDOM_SETTINGS = 5;
    localparam int RANDOM_ITEMS    = 250;
    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;

    localparam pin_result_t PINS_AT_RESET = '{1'b0, 1'b0, 1'b0, 4'h0, 1'b1, 1'b1, 1'b0};
    localparam pin_result_t HIGH_NIBBLE_A = '{1'b1, 1'b0, 1'b1, 4'hA, 1'b1, 1'b0, 1'b0};
    localparam pin_result_t REFUSED_A     = '{1'b1, 1'b0, 1'b1, 4'hA, 1'b1, 1'b0, 1'b1};
    localparam pin_result_t UNCHECKED     = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cl4_in_if  req ();
    cl4_out_if rsp ();

    char_lcd_4bit_interface uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted controller state.
    phase_t      lcd_phase;
    tick_t       count_left;
    logic [7:0]  held_byte_q;
    logic        held_sel_q;
    logic [2:0]  init_index;
    logic        init_running;
    pin_result_t pins;
    tick_t       pulse_ticks;
    tick_t       post_ticks;
    tick_t       power_ticks;
    logic [7:0]  init_bytes [4];

    pin_result_t   expected_pins [$];
    directed_row_t directed_rows [DIRECTED_ROWS];

    tick_t phase_pulse [RANDOM_SETTINGS] = '{16'd0, 16'd3, 16'd1, 16'd2, 16'd5};
    tick_t phase_post  [RANDOM_SETTINGS] = '{16'd0, 16'd2, 16'd1, 16'd0, 16'd4};
    tick_t phase_power [RANDOM_SETTINGS] = '{16'd0, 16'd5, 16'd1, 16'd12, 16'd0};

    int mismatches;
    int results_checked;
    int writes_seen;
    int inits_seen;
    int refusals;
    int busy_polls;
    int settings_used;
    int burst_left;
    int quiet_cycles;
    bit steady;
    bit hold_off_req;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void set_lines(logic rs, logic rw, logic en, logic drv, logic [3:0] data);
        pins.rs   = rs;
        pins.rw   = rw;
        pins.en   = en;
        pins.drv  = drv;
        pins.data = data;
    endfunction

    function automatic tick_t strobe_ticks();
        return (pulse_ticks == '0) ? tick_t'(1) : pulse_ticks;
    endfunction

    function automatic bit count_expired();
        if (count_left <= tick_t'(1))
        begin
            count_left = '0;
            return 1'b1;
        end
        count_left = count_left - tick_t'(1);
        return 1'b0;
    endfunction

    function automatic void load_byte(logic sel, logic [7:0] value);
        held_sel_q  = sel;
        held_byte_q = value;
        set_lines(sel, 1'b0, 1'b1, 1'b1, value[7:4]);
        count_left = strobe_ticks();
        lcd_phase  = PH_HI_EN;
    endfunction

    function automatic void byte_finished();
        if (!init_running)
        begin
            lcd_phase = PH_IDLE;
            return;
        end
        init_index = init_index + 3'd1;
        if (init_index < 3'd4)
            load_byte(1'b0, init_bytes[init_index[1:0]]);
        else if (power_ticks == '0)
        begin
            init_running = 1'b0;
            lcd_phase    = PH_IDLE;
        end
        else
        begin
            count_left = power_ticks;
            lcd_phase  = PH_PWR_POST;
        end
    endfunction

    function automatic void advance_tick(logic busy);
        case (lcd_phase)
            PH_PWR_PRE:
                if (count_expired())
                    load_byte(1'b0, init_bytes[0]);
            PH_HI_EN:
                if (count_expired())
                begin
                    pins.en   = 1'b0;
                    lcd_phase = PH_HI_GAP;
                end
            PH_HI_GAP:
            begin
                set_lines(held_sel_q, 1'b0, 1'b1, 1'b1, held_byte_q[3:0]);
                count_left = strobe_ticks();
                lcd_phase  = PH_LO_EN;
            end
            PH_LO_EN:
                if (count_expired())
                begin
                    pins.en   = 1'b0;
                    lcd_phase = PH_LO_GAP;
                end
            PH_LO_GAP:
            begin
                // D7 is released for the busy read, so it reads back as zero.
                set_lines(1'b0, 1'b1, 1'b1, 1'b0, {1'b0, pins.data[2:0]});
                lcd_phase = PH_POLL;
            end
            PH_POLL:
                if (!busy)
                begin
                    set_lines(1'b0, 1'b0, 1'b0, 1'b1, held_byte_q[3:0]);
                    if (post_ticks == '0)
                        byte_finished();
                    else
                    begin
                        count_left = post_ticks;
                        lcd_phase  = PH_POST;
                    end
                end
                else
                    busy_polls++;
            PH_POST:
                if (count_expired())
                    byte_finished();
            PH_PWR_POST:
                if (count_expired())
                begin
                    init_running = 1'b0;
                    lcd_phase    = PH_IDLE;
                end
            PH_IDLE:
                ;
            default:
                lcd_phase = PH_IDLE;
        endcase
    endfunction

    function automatic pin_result_t predict_pins(lcd_req_t r);
        pin_result_t res;
        logic        refused;
        refused = 1'b0;
        case (r.action)
            ACT_TICK:
                advance_tick(r.busy);
            ACT_WRITE, ACT_INIT:
                if (lcd_phase != PH_IDLE)
                begin
                    refused = 1'b1;
                    refusals++;
                end
                else if (r.action == ACT_WRITE)
                begin
                    init_running = 1'b0;
                    load_byte(r.sel, r.data_byte);
                    writes_seen++;
                end
                else
                begin
                    set_lines(1'b0, 1'b0, 1'b0, 1'b1, 4'h0);
                    init_running = 1'b1;
                    init_index   = 3'd0;
                    inits_seen++;
                    if (power_ticks == '0)
                        load_byte(1'b0, init_bytes[0]);
                    else
                    begin
                        count_left = power_ticks;
                        lcd_phase  = PH_PWR_PRE;
                    end
                end
            default:
                ;
        endcase
        res      = pins;
        res.idle = (lcd_phase == PH_IDLE);
        res.rej  = refused;
        return res;
    endfunction

    function automatic lcd_req_t next_request();
        lcd_req_t r;
        int       pick;
        r.sel       = 1'($urandom_range(0, 1));
        r.data_byte = 8'($urandom_range(0, 255));
        r.busy      = 1'($urandom_range(0, 1));
        pick        = $urandom_range(0, 99);
        if (lcd_phase == PH_IDLE)
        begin
            if (pick < 55)
                r.action = ACT_WRITE;
            else if (pick < 61)
                r.action = ACT_INIT;
            else if (pick < 68)
                r.action = ACT_NONE;
            else
                r.action = ACT_TICK;
        end
        else
        begin
            if (pick < 86)
                r.action = ACT_TICK;
            else if (pick < 91)
                r.action = ACT_WRITE;
            else if (pick < 95)
                r.action = ACT_INIT;
            else
                r.action = ACT_NONE;
            if (lcd_phase == PH_POLL)
                r.busy = ($urandom_range(0, 99) < 35);
        end
        return r;
    endfunction

    function automatic directed_row_t row(action_t a, logic s, logic [7:0] b, logic bz,
                                          logic typed, pin_result_t want);
        directed_row_t d;
        d.req   = '{a, s, b, bz};
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    function automatic void report_mismatch(string what, logic [15:0] want_v,
                                            logic [15:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
    endfunction

    function automatic void check_field(string what, logic [3:0] want_v, logic [3:0] got_v);
        if (got_v !== want_v)
            report_mismatch(what, 16'(want_v), 16'(got_v));
    endfunction

    task automatic offer(lcd_req_t r, logic typed, pin_result_t want);
        pin_result_t predicted;
        int          gap;
        @(negedge clk);
        req.valid      = 1'b1;
        req.action     = r.action;
        req.reg_select = r.sel;
        req.byte_value = r.data_byte;
        req.busy_pin   = r.busy;
        do @(posedge clk); while (req.ready !== 1'b1);
        predicted = predict_pins(r);
        expected_pins.push_back(typed ? want : predicted);
        if (!steady)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                @(negedge clk);
                req.valid = 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap - 1) @(negedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 24);
            end
        end
    endtask

    task automatic drain();
        lcd_req_t r;
        while (lcd_phase != PH_IDLE)
        begin
            r.action    = ACT_TICK;
            r.sel       = 1'($urandom_range(0, 1));
            r.data_byte = 8'($urandom_range(0, 255));
            r.busy      = (lcd_phase == PH_POLL) ? ($urandom_range(0, 3) == 0)
                                                 : 1'($urandom_range(0, 1));
            offer(r, 1'b0, UNCHECKED);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        req.valid = 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(reg_index_t idx, tick_t value);
        logic [APB_DATA_W-1:0] readback;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = APB_DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_ENABLE_PULSE: pulse_ticks = value;
            REG_POST_WRITE:   post_ticks  = value;
            REG_POWER_WAIT:   power_ticks = value;
            default:          ;
        endcase
        @(negedge clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback[TICK_W-1:0] !== value)
            report_mismatch(idx.name(), value, readback[TICK_W-1:0]);
    endtask

    task automatic apply_setting(tick_t pulse, tick_t post, tick_t power);
        settle();
        reg_write(REG_ENABLE_PULSE, pulse);
        reg_write(REG_POST_WRITE, post);
        reg_write(REG_POWER_WAIT, power);
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        pin_result_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (expected_pins.size() == 0)
                report_mismatch("result with no request pending", 16'h0, 16'h1);
            else
            begin
                want = expected_pins.pop_front();
                results_checked++;
                check_field("pin_rs", 4'(want.rs), 4'(rsp.pin_rs));
                check_field("pin_rw", 4'(want.rw), 4'(rsp.pin_rw));
                check_field("pin_en", 4'(want.en), 4'(rsp.pin_en));
                check_field("pin_data", want.data, rsp.pin_data);
                check_field("d7_drive", 4'(want.drv), 4'(rsp.d7_drive));
                check_field("ready_res", 4'(want.idle), 4'(rsp.ready_res));
                check_field("rejected", 4'(want.rej), 4'(rsp.rejected));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid === 1'b1 && req.ready === 1'b1)
                    || (rsp.valid === 1'b1 && rsp.ready === 1'b1) || psel)
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // The sink runs in stretches that are either always ready or stall at random.
    initial
    begin
        int run_left;
        bit choppy;
        rsp.ready = 1'b0;
        run_left  = 0;
        choppy    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp.ready    = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (run_left == 0)
            begin
                choppy   = ($urandom_range(0, 2) != 0);
                run_left = $urandom_range(5, 60);
            end
            run_left--;
            rsp.ready = (steady || !choppy) ? 1'b1 : ($urandom_range(0, 99) >= 40);
        end
    end

    initial
    begin
        lcd_req_t r;
        int       counted;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req.valid      = 1'b0;
        req.action     = ACT_TICK;
        req.reg_select = 1'b0;
        req.byte_value = 8'h00;
        req.busy_pin   = 1'b0;
        steady         = 1'b0;
        hold_off_req   = 1'b0;
        burst_left     = 1;
        quiet_cycles   = 0;

        lcd_phase    = PH_IDLE;
        count_left   = '0;
        held_byte_q  = 8'h00;
        held_sel_q   = 1'b0;
        init_index   = 3'd0;
        init_running = 1'b0;
        pins         = PINS_AT_RESET;
        pulse_ticks  = 16'd1;
        post_ticks   = 16'd3;
        power_ticks  = 16'd200;
        init_bytes   = '{CMD_FUNCTION_SET, CMD_DISPLAY_ON, CMD_ENTRY_MODE, CMD_CLEAR};

        directed_rows = '{
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b1, PINS_AT_RESET),
            row(ACT_NONE,  1'b1, 8'hFF, 1'b1, 1'b1, PINS_AT_RESET),
            row(ACT_WRITE, 1'b1, 8'hA5, 1'b0, 1'b1, HIGH_NIBBLE_A),
            row(ACT_WRITE, 1'b0, 8'h00, 1'b1, 1'b1, REFUSED_A),
            row(ACT_INIT,  1'b0, 8'h00, 1'b0, 1'b1, REFUSED_A),
            row(ACT_TICK,  1'b0, 8'h00, 1'b1, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b1, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b1, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b1, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_WRITE, 1'b0, 8'hFF, 1'b1, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_TICK,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED),
            row(ACT_INIT,  1'b0, 8'h00, 1'b0, 1'b0, UNCHECKED)
        };

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain();

        for (int p = 0; p < RANDOM_SETTINGS; p++)
        begin
            apply_setting(phase_pulse[p], phase_post[p], phase_power[p]);
            counted = 0;
            while (counted < RANDOM_ITEMS)
            begin
                r = next_request();
                // One long sink hold-off lets the result register fill and stall requests.
                if (p == 1 && counted == 120)
                    hold_off_req = 1'b1;
                offer(r, 1'b0, UNCHECKED);
                if (r.action != ACT_NONE)
                    counted++;
            end
            drain();
        end

        // Widest register values are read back, then an init runs with a longer power-up wait.
        steady = 1'b1;
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
        apply_setting(16'd1, 16'd0, 16'd40);
        r = '{ACT_INIT, 1'b0, 8'h00, 1'b0};
        offer(r, 1'b0, UNCHECKED);
        drain();
        steady = 1'b0;

        @(negedge clk);
        req.valid = 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_pins.size() != 0)
            report_mismatch("results never delivered", 16'(expected_pins.size()), 16'h0);

        $display("Covered %0d writes, %0d inits, %0d refused requests, %0d busy polls.",
                 writes_seen, inits_seen, refusals, busy_polls);
        $display("Compared %0d results across %0d register settings, %0d mismatches.",
                 results_checked, settings_used + 1, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* char_lcd_4bit_interface.f */
hdl/cl4_pkg.sv
hdl/cl4_in_if.sv
hdl/cl4_out_if.sv
hdl/char_lcd_4bit_interface.sv
test/testbench.sv
